### design/qvpc_pkg.sv
// ----------------------------------------------------------------------------
// qvpc_pkg
// Shared widths, codes and bundle types for the quaternion vector-part
// converter.
// ----------------------------------------------------------------------------
package qvpc_pkg;

    localparam int FRAC_BITS_DEF  = 30;
    localparam int COMP_WIDTH_DEF = 32;

    localparam int FIELD_W     = 32;
    localparam int MAG_W       = 32;
    localparam int NUM_COMP    = 4;
    localparam int NUM_LANES   = 3;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SQX_W       = SQ_W + 1;
    localparam int SUM_W       = SQ_W + 1;
    localparam int RAD_W       = SQ_W - 1;
    localparam int ROOT_W      = 32;
    localparam int SQRT_STAGES = SQ_W / 2;
    localparam int NORM_STEPS  = 5;

    typedef enum logic {
        OP_Q2V = 1'b0,
        OP_V2Q = 1'b1
    } t_op;

    // front end bundle: all four components
    typedef struct packed {
        t_op                               op;
        logic                              zero;
        logic [NUM_COMP-1:0]               neg;
        logic [MAG_W-1:0]                  max;
        logic [NUM_COMP-1:0][MAG_W-1:0]    mag;
    } t_front;

    // back end bundle: vector lanes plus the sign of w
    typedef struct packed {
        t_op                               op;
        logic                              bad;
        logic                              neg_w;
        logic [NUM_LANES-1:0]              neg;
        logic [NUM_LANES-1:0][MAG_W-1:0]   mag;
    } t_side;

    typedef struct packed {
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
        logic               bad;
    } t_result;

endpackage

### design/quaternion_vector_part_convert.sv
// ----------------------------------------------------------------------------
// quaternion_vector_part_convert
// Unit quaternion normalize (mode 0) and scalar recovery (mode 1) on signed
// fixed-point components, fully pipelined with three divider lanes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  input    | in        | i_valid / o_ready  | i_operation, i_in_w..i_in_z
//  output   | out       | o_valid / i_ready  | o_out_w..o_out_z, o_bad_input
//
//  one item per cycle while the output is not stalled; the pipeline depth is
//  set by the 32-stage square root and the FRAC_BITS+2 divider stages
//  no state is kept between items; reset only clears the valid pipeline
//  when a result is stuck, one more result goes to the skid entry and then
//  the whole pipeline holds and o_ready drops until the output is taken
// ----------------------------------------------------------------------------
module quaternion_vector_part_convert import qvpc_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_operation,
    input  logic signed [FIELD_W-1:0] i_in_w,
    input  logic signed [FIELD_W-1:0] i_in_x,
    input  logic signed [FIELD_W-1:0] i_in_y,
    input  logic signed [FIELD_W-1:0] i_in_z,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [FIELD_W-1:0] o_out_w,
    output logic signed [FIELD_W-1:0] o_out_x,
    output logic signed [FIELD_W-1:0] o_out_y,
    output logic signed [FIELD_W-1:0] o_out_z,
    output logic                      o_bad_input
);

    localparam int Q_W   = FRAC_BITS + 2;
    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam logic [SUM_W-1:0] LIM = SUM_W'(1) << (2 * FRAC_BITS);
    localparam logic [Q_W-1:0]   ONE = Q_W'(1) << FRAC_BITS;

    logic    w_full;
    logic    w_en;
    logic    w_push;
    t_result w_res;
    t_result w_out;

    assign w_en    = !w_full;
    assign o_ready = w_en;

    // input capture: sign extend and take magnitudes
    logic [FIELD_W-1:0] w_in [NUM_COMP];
    t_front             w_a;

    assign w_in[0] = i_in_w;
    assign w_in[1] = i_in_x;
    assign w_in[2] = i_in_y;
    assign w_in[3] = i_in_z;

    always_comb begin
        logic [FIELD_W-1:0] v_sx;
        w_a      = '0;
        w_a.op   = t_op'(i_operation);
        for (int k = 0; k < NUM_COMP; k++) begin
            v_sx         = FIELD_W'(signed'(w_in[k][COMP_WIDTH-1:0]));
            w_a.neg[k]   = v_sx[FIELD_W-1];
            w_a.mag[k]   = v_sx[FIELD_W-1] ? MAG_W'(0 - v_sx) : v_sx;
        end
    end

    logic   r_a_v;
    t_front r_a_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_f <= w_a;
        end
    end

    // largest magnitude over the four components
    logic [MAG_W-1:0] w_m01;
    logic [MAG_W-1:0] w_m23;
    t_front           w_b;
    logic             r_b_v;
    t_front           r_b_f;

    always_comb begin
        w_m01    = (r_a_f.mag[0] > r_a_f.mag[1]) ? r_a_f.mag[0] : r_a_f.mag[1];
        w_m23    = (r_a_f.mag[2] > r_a_f.mag[3]) ? r_a_f.mag[2] : r_a_f.mag[3];
        w_b      = r_a_f;
        w_b.max  = (w_m01 > w_m23) ? w_m01 : w_m23;
        w_b.zero = (w_b.max == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_f <= w_b;
        end
    end

    // normalize (mode 0 only): shift by 16, 8, 4, 2, 1 until the max reaches 2^30
    logic [NORM_STEPS-1:0] r_nm_v;
    t_front                r_nm_f [NORM_STEPS];

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - k);
        logic   w_v;
        t_front w_f;
        t_front n_f;
        logic   w_sh;

        if (k == 0) begin : g_first
            assign w_v = r_b_v;
            assign w_f = r_b_f;
        end else begin : g_next
            assign w_v = r_nm_v[k-1];
            assign w_f = r_nm_f[k-1];
        end

        always_comb begin
            n_f  = w_f;
            w_sh = (w_f.op == OP_Q2V) && (w_f.max[MAG_W-1 -: SH+1] == '0);
            if (w_sh) begin
                n_f.max = w_f.max << SH;
                for (int c = 0; c < NUM_COMP; c++) begin
                    n_f.mag[c] = w_f.mag[c] << SH;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nm_v[k] <= 1'b0;
            end else if (w_en) begin
                r_nm_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_nm_f[k] <= n_f;
            end
        end
    end

    // squares, one multiplier per component
    logic                          r_sq_v;
    t_front                        r_sq_f;
    logic [NUM_COMP-1:0][SQ_W-1:0] r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (w_en) begin
            r_sq_v <= r_nm_v[NORM_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_f <= r_nm_f[NORM_STEPS-1];
            for (int c = 0; c < NUM_COMP; c++) begin
                r_sq[c] <= r_nm_f[NORM_STEPS-1].mag[c] * r_nm_f[NORM_STEPS-1].mag[c];
            end
        end
    end

    // sum of squares in two adder levels; w is left out in mode 1
    logic              r_s1_v;
    t_front            r_s1_f;
    logic [SQ_W-1:0]   r_p0;
    logic [SQ_W-1:0]   r_p1;
    logic              r_s2_v;
    t_front            r_s2_f;
    logic [SUM_W-1:0]  r_tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= r_sq_v;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_f <= r_sq_f;
            r_p0   <= ((r_sq_f.op == OP_V2Q) ? '0 : r_sq[0]) + r_sq[1];
            r_p1   <= r_sq[2] + r_sq[3];
            r_s2_f <= r_s1_f;
            r_tot  <= SUM_W'(r_p0) + SUM_W'(r_p1);
        end
    end

    // radicand and error flag
    logic             r_rd_v;
    t_side            r_rd_s;
    logic [RAD_W-1:0] r_rd_rad;
    t_side            w_rd_s;
    logic [RAD_W-1:0] w_rd_rad;

    always_comb begin
        w_rd_s.op    = r_s2_f.op;
        w_rd_s.neg_w = r_s2_f.neg[0];
        for (int l = 0; l < NUM_LANES; l++) begin
            w_rd_s.neg[l] = r_s2_f.neg[l+1];
            w_rd_s.mag[l] = r_s2_f.mag[l+1];
        end
        if (r_s2_f.op == OP_V2Q) begin
            w_rd_s.bad = (r_tot > LIM);
            w_rd_rad   = RAD_W'((LIM - r_tot) << 2);
        end else begin
            w_rd_s.bad = r_s2_f.zero;
            w_rd_rad   = r_tot[SUM_W-1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else if (w_en) begin
            r_rd_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd_s   <= w_rd_s;
            r_rd_rad <= w_rd_rad;
        end
    end

    // shared square root, side data delayed alongside
    logic [ROOT_W-1:0]      w_root;
    logic [SQRT_STAGES-1:0] r_sr_v;
    t_side                  r_sr_s [SQRT_STAGES];

    qvpc_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_rd_rad),
        .o_root (w_root)
    );

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sr
        logic  w_v;
        t_side w_s;

        if (s == 0) begin : g_first
            assign w_v = r_rd_v;
            assign w_s = r_rd_s;
        end else begin : g_next
            assign w_v = r_sr_v[s-1];
            assign w_s = r_sr_s[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sr_v[s] <= 1'b0;
            end else if (w_en) begin
                r_sr_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sr_s[s] <= w_s;
            end
        end
    end

    // numerators with rounding term
    logic                             r_d0_v;
    t_side                            r_d0_s;
    logic [ROOT_W-1:0]                r_d0_root;
    logic [NUM_LANES-1:0][NUM_W-1:0]  r_d0_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_v <= 1'b0;
        end else if (w_en) begin
            r_d0_v <= r_sr_v[SQRT_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d0_s    <= r_sr_s[SQRT_STAGES-1];
            r_d0_root <= w_root;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_d0_num[l] <= (NUM_W'(r_sr_s[SQRT_STAGES-1].mag[l]) << (FRAC_BITS - 1))
                               + NUM_W'(w_root >> 1);
            end
        end
    end

    // divider lanes
    logic [Q_W-1:0] w_quot [NUM_LANES];

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        qvpc_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_d0_num[l]),
            .i_den  (r_d0_root),
            .o_quot (w_quot[l])
        );
    end

    logic [Q_W-1:0]    r_dv_v;
    t_side             r_dv_s    [Q_W];
    logic [ROOT_W-1:0] r_dv_root [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_dv
        logic              w_v;
        t_side             w_s;
        logic [ROOT_W-1:0] w_r;

        if (s == 0) begin : g_first
            assign w_v = r_d0_v;
            assign w_s = r_d0_s;
            assign w_r = r_d0_root;
        end else begin : g_next
            assign w_v = r_dv_v[s-1];
            assign w_s = r_dv_s[s-1];
            assign w_r = r_dv_root[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[s] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_s[s]    <= w_s;
                r_dv_root[s] <= w_r;
            end
        end
    end

    // merge lanes: saturate, apply signs, pick mode
    t_side               w_fs;
    logic [ROOT_W:0]     w_wround;
    logic [FIELD_W-1:0]  w_lane [NUM_LANES];

    assign w_fs = r_dv_s[Q_W-1];

    always_comb begin
        logic [Q_W-1:0]     v_q;
        logic [FIELD_W-1:0] v_m;
        v_q      = '0;
        v_m      = '0;
        w_wround = ({1'b0, r_dv_root[Q_W-1]} + 1'b1) >> 1;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (w_fs.op == OP_V2Q) begin
                v_m       = FIELD_W'(w_fs.mag[l]);
                w_lane[l] = w_fs.neg[l] ? FIELD_W'(0 - v_m) : v_m;
            end else begin
                v_q       = (w_quot[l] > ONE) ? ONE : w_quot[l];
                v_m       = FIELD_W'(v_q);
                w_lane[l] = (w_fs.neg[l] ^ w_fs.neg_w) ? FIELD_W'(0 - v_m) : v_m;
            end
        end
        w_res.bad = w_fs.bad;
        if (w_fs.bad) begin
            w_res.w = '0;
            w_res.x = '0;
            w_res.y = '0;
            w_res.z = '0;
        end else begin
            w_res.w = (w_fs.op == OP_V2Q) ? FIELD_W'(w_wround) : '0;
            w_res.x = w_lane[0];
            w_res.y = w_lane[1];
            w_res.z = w_lane[2];
        end
    end

    assign w_push = w_en && r_dv_v[Q_W-1];

    qvpc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out)
    );

    assign o_out_w     = w_out.w;
    assign o_out_x     = w_out.x;
    assign o_out_y     = w_out.y;
    assign o_out_z     = w_out.z;
    assign o_bad_input = w_out.bad;

endmodule

### design/qvpc_isqrt.sv
// ----------------------------------------------------------------------------
// qvpc_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qvpc_isqrt import qvpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0] r_rem [SQRT_STAGES];
    logic [SQ_W-1:0] r_res [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        localparam logic [SQX_W-1:0] BIT = SQX_W'(1) << (SQ_W - 2 - 2 * s);
        logic [SQ_W-1:0]  w_rem;
        logic [SQ_W-1:0]  w_res;
        logic [SQX_W-1:0] w_trial;
        logic [SQ_W-1:0]  n_rem;
        logic [SQ_W-1:0]  n_res;

        if (s == 0) begin : g_first
            assign w_rem = {1'b0, i_rad};
            assign w_res = '0;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_res = r_res[s-1];
        end

        always_comb begin
            w_trial = {1'b0, w_res} + BIT;
            if ({1'b0, w_rem} >= w_trial) begin
                n_rem = SQ_W'({1'b0, w_rem} - w_trial);
                n_res = SQ_W'({1'b0, w_res >> 1} + BIT);
            end else begin
                n_rem = w_rem;
                n_res = w_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_res[s] <= n_res;
            end
        end
    end

    assign o_root = ROOT_W'(r_res[SQRT_STAGES-1]);

endmodule

### design/qvpc_div.sv
// ----------------------------------------------------------------------------
// qvpc_div
// Pipelined restoring divider for one vector lane, one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module qvpc_div import qvpc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [MAG_W+FRAC_BITS-1:0] i_num,
    input  logic [ROOT_W-1:0]          i_den,
    output logic [FRAC_BITS+1:0]       o_quot
);

    localparam int Q_W   = FRAC_BITS + 2;
    localparam int REM_W = MAG_W + FRAC_BITS + 1;

    logic [REM_W-1:0]  r_rem  [Q_W];
    logic [ROOT_W-1:0] r_den  [Q_W];
    logic [Q_W-1:0]    r_quot [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int SH = Q_W - 1 - s;
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_den;
        logic [Q_W-1:0]    w_quot;
        logic [REM_W-1:0]  w_dsh;
        logic              w_ge;
        logic [REM_W-1:0]  n_rem;
        logic [Q_W-1:0]    n_quot;

        if (s == 0) begin : g_first
            assign w_rem  = REM_W'(i_num);
            assign w_den  = i_den;
            assign w_quot = '0;
        end else begin : g_next
            assign w_rem  = r_rem[s-1];
            assign w_den  = r_den[s-1];
            assign w_quot = r_quot[s-1];
        end

        always_comb begin
            w_dsh  = REM_W'(w_den) << SH;
            w_ge   = (w_rem >= w_dsh);
            n_rem  = w_ge ? (w_rem - w_dsh) : w_rem;
            n_quot = {w_quot[Q_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_den[s]  <= w_den;
                r_quot[s] <= n_quot;
            end
        end
    end

    assign o_quot = r_quot[Q_W-1];

endmodule

### design/qvpc_skid.sv
// ----------------------------------------------------------------------------
// qvpc_skid
// Output register with one skid entry; the pipeline halts only while the
// skid entry is occupied.
// ----------------------------------------------------------------------------
module qvpc_skid import qvpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out_d;
    t_result r_skid_d;
    logic    n_out_v;
    logic    n_skid_v;
    logic    w_take;
    logic    w_load_out;
    logic    w_load_skid;
    logic    w_from_skid;

    always_comb begin
        w_take      = r_out_v && i_ready;
        n_out_v     = r_out_v;
        n_skid_v    = r_skid_v;
        w_load_out  = 1'b0;
        w_load_skid = 1'b0;
        w_from_skid = 1'b0;
        if (i_push) begin
            if (!r_out_v || w_take) begin
                n_out_v    = 1'b1;
                w_load_out = 1'b1;
            end else begin
                n_skid_v    = 1'b1;
                w_load_skid = 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_v) begin
                w_from_skid = 1'b1;
                n_skid_v    = 1'b0;
            end else begin
                n_out_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_d <= i_data;
        end else if (w_from_skid) begin
            r_out_d <= r_skid_d;
        end
        if (w_load_skid) begin
            r_skid_d <= i_data;
        end
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out_d;

endmodule

### bench/tb_quaternion_vector_part_convert.sv
// ----------------------------------------------------------------------------
// tb_quaternion_vector_part_convert
// Drives quaternion and vector-part items through the converter with random
// gaps on both channels, predicts every result from exact integer math and
// compares each returned item field by field, in order.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_part_convert;
    import qvpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC   = 30;
    localparam int LAT    = 47 + FRAC;
    localparam int N_RAND = 1930;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic                      i_operation = 1'b0;
    logic signed [FIELD_W-1:0] i_in_w = '0;
    logic signed [FIELD_W-1:0] i_in_x = '0;
    logic signed [FIELD_W-1:0] i_in_y = '0;
    logic signed [FIELD_W-1:0] i_in_z = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic signed [FIELD_W-1:0] o_out_w;
    logic signed [FIELD_W-1:0] o_out_x;
    logic signed [FIELD_W-1:0] o_out_y;
    logic signed [FIELD_W-1:0] o_out_z;
    logic                      o_bad_input;

    t_result expected_q[$];
    int      n_err = 0;
    bit      stall_free = 1'b0;
    bit      out_taken = 1'b0;
    int      rdy_gap = 0;

    quaternion_vector_part_convert DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_result convert(input t_op op, input logic signed [31:0] c[4]);
        t_result     res;
        logic [63:0] a[4];
        logic [3:0]  neg;
        logic [63:0] m;
        logic [63:0] s4;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] lo;
        logic [63:0] s;
        logic [63:0] lim;
        logic signed [31:0] lane[4];
        res = '0;
        m = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = c[i][31];
            a[i] = neg[i] ? 64'(-64'(signed'(c[i]))) : 64'(c[i]);
            if (a[i] > m) m = a[i];
        end
        if (op == OP_Q2V) begin
            if (m == 0) begin
                res.bad = 1'b1;
            end else begin
                while (m < (64'd1 << 30)) begin
                    m = m << 1;
                    for (int i = 0; i < 4; i++) a[i] = a[i] << 1;
                end
                s4 = 0;
                lo = 0;
                for (int i = 0; i < 4; i++) begin
                    s4 += (a[i] * a[i]) >> 2;
                    lo += (a[i] * a[i]) & 64'd3;
                end
                mag = root_floor(s4 + (lo >> 2));
                for (int i = 1; i < 4; i++) begin
                    q = ((a[i] << (FRAC - 1)) + (mag >> 1)) / mag;
                    if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
                    lane[i] = (neg[i] != neg[0]) ? -32'(q) : 32'(q);
                end
                res.x = lane[1];
                res.y = lane[2];
                res.z = lane[3];
            end
        end else begin
            lim = 64'd1 << (2 * FRAC);
            s = a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
            if (s > lim) begin
                res.bad = 1'b1;
            end else begin
                res.w = 32'((root_floor((lim - s) << 2) + 1) >> 1);
                res.x = c[1];
                res.y = c[2];
                res.z = c[3];
            end
        end
        return res;
    endfunction

    task automatic send_item(input t_op op, input logic signed [31:0] w, x, y, z);
        logic signed [31:0] c[4];
        int                 gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        c = '{w, x, y, z};
        expected_q.push_back(convert(op, c));
        i_valid     <= 1'b1;
        i_operation <= op;
        i_in_w <= w;
        i_in_x <= x;
        i_in_y <= y;
        i_in_z <= z;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        out_taken = i_rst_n && o_valid && i_ready;
    end

    // result side: random wait before each item, none while stall_free
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rdy_gap = $urandom_range(0, 3);
        end else begin
            if (out_taken) rdy_gap = stall_free ? 0 : $urandom_range(0, 3);
            if (rdy_gap > 0) begin
                rdy_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected item w=%h", o_out_w);
            end else begin
                exp_r = expected_q.pop_front();
                if (o_out_w !== exp_r.w || o_out_x !== exp_r.x || o_out_y !== exp_r.y ||
                    o_out_z !== exp_r.z || o_bad_input !== exp_r.bad) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch exp %h %h %h %h %b got %h %h %h %h %b",
                                 exp_r.w, exp_r.x, exp_r.y, exp_r.z, exp_r.bad,
                                 o_out_w, o_out_x, o_out_y, o_out_z, o_bad_input);
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return 32'($urandom_range(0, 255)) - 128;
            default: return 32'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
        endcase
    endfunction

    task automatic test_directed();
        send_item(OP_Q2V, 0, 0, 0, 0);
        send_item(OP_Q2V, 32'sh4000_0000, 0, 0, 0);
        send_item(OP_Q2V, -32'sh4000_0000, 5, -7, 0);
        send_item(OP_Q2V, 0, 1, 0, 0);
        send_item(OP_Q2V, 0, -1, 1, -1);
        send_item(OP_Q2V, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_item(OP_Q2V, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_item(OP_Q2V, 32'sh7fffffff, 32'sh80000000, 1, -1);
        send_item(OP_Q2V, -1, 0, 0, 0);
        send_item(OP_V2Q, 32'sh7fffffff, 0, 0, 0);
        send_item(OP_V2Q, 0, 32'sh4000_0000, 0, 0);
        send_item(OP_V2Q, 0, 32'sh4000_0001, 0, 0);
        send_item(OP_V2Q, 0, -32'sh4000_0000, 0, 0);
        send_item(OP_V2Q, 0, 32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000);
        send_item(OP_V2Q, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_item(OP_V2Q, -1, 32'sh7fffffff, 0, 0);
        send_item(OP_V2Q, 32'sh80000000, 1, -1, 1);
    endtask

    task automatic test_random();
        for (int n = 0; n < N_RAND; n++) begin
            stall_free = ((n / 200) % 3 == 2);
            send_item($urandom_range(0, 1) ? OP_V2Q : OP_Q2V,
                      rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
        stall_free = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        if (n_err == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
design/qvpc_pkg.sv
design/qvpc_isqrt.sv
design/qvpc_div.sv
design/qvpc_skid.sv
design/quaternion_vector_part_convert.sv
bench/tb_quaternion_vector_part_convert.sv
